// File: design/bps_pkg.sv
package bps_pkg;

  localparam int ADC_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef struct packed {
    logic [ADC_W-1:0] adc_count;
    logic             charging;
  } in_item_t;

  typedef struct packed {
    logic [7:0] battery_percent;
    logic [1:0] warning_event;
  } out_item_t;

  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd5;

  localparam logic [12:0] CRITICAL_RST  = 13'd3500;
  localparam logic [12:0] RANGE_RST     = 13'd600;
  localparam logic [9:0]  TENTH_RST     = 10'd60;
  localparam logic [6:0]  WARN_RST      = 7'd20;
  localparam logic [6:0]  RADIO_OFF_RST = 7'd10;
  localparam logic [9:0]  OFFSET_RST    = 10'd0;

  // count * 156500000 / 99508500 as a multiply by the reciprocal scaled by 2^30,
  // exact for every 12-bit count
  localparam int          PROD_W   = 43;
  localparam int          MV_SHIFT = 30;
  localparam logic [30:0] MV_MUL   = 31'd1688705945;

  localparam int DIV_REM_W = 18;
  localparam int DIV_DVD_W = 13;
  localparam int DIV_CNT_W = 4;

  localparam logic [DIV_CNT_W-1:0] PCT_ITERS = 4'd8;
  localparam logic [DIV_CNT_W-1:0] AVG_ITERS = 4'd8;

  localparam logic [1:0] SRC_PCT = 2'd1;
  localparam logic [1:0] SRC_AVG = 2'd2;

  localparam logic [1:0] SEV_NONE  = 2'd0;
  localparam logic [1:0] SEV_LOW   = 2'd1;
  localparam logic [1:0] SEV_RADIO = 2'd2;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_LOW   = 2'd1;
  localparam logic [1:0] EVT_RADIO = 2'd2;

  localparam int SLEW_BIG   = 2;
  localparam int SLEW_SMALL = 1;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       div_start;
    logic [1:0] div_src;
    logic       calc_above;
    logic       write_entry;
    logic       walk_rd;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

// File: design/bps_divider.sv
module bps_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bps_pkg::DIV_REM_W-1:0]  rem_init,
  input  logic [bps_pkg::DIV_DVD_W-1:0]  dvd_init,
  input  logic [bps_pkg::DIV_REM_W-1:0]  divisor,
  input  logic [bps_pkg::DIV_CNT_W-1:0]  iters,
  output logic                           done,
  output logic [bps_pkg::DIV_DVD_W-1:0]  quotient,
  output logic [bps_pkg::DIV_REM_W-1:0]  remainder
);

  logic [bps_pkg::DIV_REM_W-1:0] rem_r;
  logic [bps_pkg::DIV_DVD_W-1:0] dvd_r;
  logic [bps_pkg::DIV_DVD_W-1:0] quo_r;
  logic [bps_pkg::DIV_REM_W-1:0] divisor_r;
  logic [bps_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          running_r;
  logic                          done_r;

  logic [bps_pkg::DIV_REM_W:0]   shifted;
  logic [bps_pkg::DIV_REM_W+1:0] diff;
  logic                          fits;

  // one restoring step per cycle
  assign shifted = {rem_r, dvd_r[bps_pkg::DIV_DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_r};
  assign fits    = ~diff[bps_pkg::DIV_REM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= iters;
      end else if (running_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bps_pkg::DIV_CNT_W'(1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= rem_init;
      dvd_r     <= dvd_init;
      quo_r     <= '0;
      divisor_r <= divisor;
    end else if (running_r) begin
      rem_r <= fits ? diff[bps_pkg::DIV_REM_W-1:0] : shifted[bps_pkg::DIV_REM_W-1:0];
      dvd_r <= {dvd_r[bps_pkg::DIV_DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[bps_pkg::DIV_DVD_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: design/bps_ctrl.sv
module bps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output bps_pkg::cmd_t cmd,
  input  bps_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_ABOVE    = 4'd4;
  localparam logic [3:0] S_PCT_GO   = 4'd5;
  localparam logic [3:0] S_PCT_WAIT = 4'd6;
  localparam logic [3:0] S_WRITE    = 4'd7;
  localparam logic [3:0] S_WALK     = 4'd8;
  localparam logic [3:0] S_WALK_END = 4'd9;
  localparam logic [3:0] S_AVG_GO   = 4'd10;
  localparam logic [3:0] S_AVG_WAIT = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ABOVE;
      end
      S_ABOVE: begin
        cmd.calc_above = 1'b1;
        state_nxt      = S_PCT_GO;
      end
      S_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = bps_pkg::SRC_PCT;
        state_nxt     = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (sts.div_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_nxt       = S_WALK;
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) state_nxt = S_WALK_END;
      end
      S_WALK_END: begin
        state_nxt = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = bps_pkg::SRC_AVG;
        state_nxt     = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/bps_datapath.sv
module bps_datapath #(
  parameter int SAMPLE_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bps_pkg::cmd_t                     cmd,
  output bps_pkg::sts_t                     sts,
  input  bps_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bps_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W  = $clog2(SAMPLE_COUNT);
  localparam int FILL_W = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W  = 8 + $clog2(SAMPLE_COUNT);
  localparam int HALF_N = SAMPLE_COUNT / 2;

  // configuration
  logic [12:0] critical_r;
  logic [12:0] range_r;
  logic [9:0]  tenth_r;
  logic [6:0]  warn_r;
  logic [6:0]  radio_off_r;
  logic [9:0]  offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      critical_r  <= bps_pkg::CRITICAL_RST;
      range_r     <= bps_pkg::RANGE_RST;
      tenth_r     <= bps_pkg::TENTH_RST;
      warn_r      <= bps_pkg::WARN_RST;
      radio_off_r <= bps_pkg::RADIO_OFF_RST;
      offset_r    <= bps_pkg::OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bps_pkg::REG_CRITICAL:  critical_r  <= cfg_data[12:0];
        bps_pkg::REG_RANGE:     range_r     <= cfg_data[12:0];
        bps_pkg::REG_TENTH:     tenth_r     <= cfg_data[9:0];
        bps_pkg::REG_WARN:      warn_r      <= cfg_data[6:0];
        bps_pkg::REG_RADIO_OFF: radio_off_r <= cfg_data[6:0];
        bps_pkg::REG_OFFSET:    offset_r    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [bps_pkg::ADC_W-1:0]  count_r;
  logic                       chg_r;
  logic [bps_pkg::PROD_W-1:0] prod_r;
  logic [12:0]                above_r;
  logic                       sat_r;

  // shared divider
  logic                          div_done;
  logic [bps_pkg::DIV_DVD_W-1:0] div_quo;
  logic [bps_pkg::DIV_REM_W-1:0] div_rem;
  logic [bps_pkg::DIV_REM_W-1:0] div_rem_init;
  logic [bps_pkg::DIV_DVD_W-1:0] div_dvd_init;
  logic [bps_pkg::DIV_REM_W-1:0] div_divisor;
  logic [bps_pkg::DIV_CNT_W-1:0] div_iters;

  // sample ring
  logic [7:0]        ring_mem [SAMPLE_COUNT];
  logic [IDX_W-1:0]  slot_r;
  logic [FILL_W-1:0] fill_r;
  logic [7:0]        last_r;
  logic [IDX_W-1:0]  walk_idx_r;
  logic [7:0]        rd_r;
  logic              rd_pend_r;
  logic [SUM_W-1:0]  acc_r;

  logic [1:0]        sev_r;
  logic              out_valid_r;
  bps_pkg::out_item_t out_data_r;

  logic [16:0] pct_dvd;
  logic        ring_full;

  assign pct_dvd   = 17'(above_r) * 17'd10;
  assign ring_full = (fill_r == FILL_W'(SAMPLE_COUNT));

  always_comb begin
    case (cmd.div_src)
      bps_pkg::SRC_PCT: begin
        div_rem_init = bps_pkg::DIV_REM_W'(pct_dvd[16:8]);
        div_dvd_init = {pct_dvd[7:0], 5'b0};
        div_divisor  = bps_pkg::DIV_REM_W'(tenth_r);
        div_iters    = bps_pkg::PCT_ITERS;
      end
      default: begin
        div_rem_init = bps_pkg::DIV_REM_W'(acc_r >> 8);
        div_dvd_init = {acc_r[7:0], 5'b0};
        div_divisor  = bps_pkg::DIV_REM_W'(fill_r);
        div_iters    = bps_pkg::AVG_ITERS;
      end
    endcase
  end

  bps_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .rem_init  (div_rem_init),
    .dvd_init  (div_dvd_init),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // millivolts above critical, clamped to the range
  logic [12:0]        mv_val;
  logic signed [14:0] above_s;
  logic [12:0]        above_val;

  assign mv_val  = prod_r[bps_pkg::PROD_W-1:bps_pkg::MV_SHIFT];
  assign above_s = $signed({2'b00, mv_val}) + $signed({{5{offset_r[9]}}, offset_r})
                 - $signed({2'b00, critical_r});

  always_comb begin
    if (above_s[14] || above_s == 15'sd0) begin
      above_val = '0;
    end else if (above_s[12:0] > range_r) begin
      above_val = range_r;
    end else begin
      above_val = above_s[12:0];
    end
  end

  // rounded percent and slew limit
  logic [8:0]        pct_round;
  logic [7:0]        pct;
  logic signed [9:0] gap;
  logic signed [9:0] up_lim;
  logic signed [9:0] down_lim;
  logic signed [9:0] gap_lim;
  logic signed [9:0] entry_s;
  logic [7:0]        entry;

  assign pct_round = {1'b0, div_quo[7:0]}
                   + 9'(div_rem > bps_pkg::DIV_REM_W'(tenth_r >> 1));
  assign pct       = (sat_r || pct_round[8]) ? 8'd255 : pct_round[7:0];
  assign gap       = $signed({2'b00, pct}) - $signed({2'b00, last_r});
  assign up_lim    = chg_r ? 10'(bps_pkg::SLEW_BIG) : 10'(bps_pkg::SLEW_SMALL);
  assign down_lim  = chg_r ? -10'(bps_pkg::SLEW_SMALL) : -10'(bps_pkg::SLEW_BIG);

  always_comb begin
    if (gap > up_lim) begin
      gap_lim = up_lim;
    end else if (gap < down_lim) begin
      gap_lim = down_lim;
    end else begin
      gap_lim = gap;
    end
    entry_s = $signed({2'b00, last_r}) + gap_lim;
    if (!ring_full) begin
      entry = pct;
    end else if (entry_s[9]) begin
      entry = 8'd0;
    end else if (entry_s[8]) begin
      entry = 8'd255;
    end else begin
      entry = entry_s[7:0];
    end
  end

  // rounded average and severity
  logic       avg_up;
  logic [8:0] avg_round;
  logic [7:0] avg;
  logic [1:0] sev_nxt;
  logic [1:0] evt;

  assign avg_up    = ring_full ? (div_rem >= bps_pkg::DIV_REM_W'(HALF_N))
                               : (div_rem > bps_pkg::DIV_REM_W'(fill_r >> 1));
  assign avg_round = {1'b0, div_quo[7:0]} + 9'(avg_up);
  assign avg       = avg_round[8] ? 8'd255 : avg_round[7:0];

  always_comb begin
    sev_nxt = sev_r;
    evt     = bps_pkg::EVT_NONE;
    if (chg_r) begin
      sev_nxt = bps_pkg::SEV_NONE;
    end else if (avg < {1'b0, warn_r}) begin
      if (avg < {1'b0, radio_off_r} && sev_r == bps_pkg::SEV_LOW) begin
        sev_nxt = bps_pkg::SEV_RADIO;
        evt     = bps_pkg::EVT_RADIO;
      end else if (avg >= {1'b0, radio_off_r} && sev_r == bps_pkg::SEV_NONE) begin
        sev_nxt = bps_pkg::SEV_LOW;
        evt     = bps_pkg::EVT_LOW;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      count_r <= in_data.adc_count;
      chg_r   <= in_data.charging;
    end
    if (cmd.mul) begin
      prod_r <= bps_pkg::PROD_W'(count_r) * bps_pkg::PROD_W'(bps_pkg::MV_MUL);
    end
    if (cmd.calc_above) begin
      above_r <= above_val;
    end
    if (cmd.div_start && cmd.div_src == bps_pkg::SRC_PCT) begin
      sat_r <= {1'b0, pct_dvd} >= {tenth_r, 8'b0};
    end
    if (cmd.write_entry) begin
      ring_mem[slot_r] <= entry;
      last_r           <= entry;
    end
    if (cmd.walk_rd) begin
      rd_r <= ring_mem[walk_idx_r];
    end
    if (cmd.write_entry) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= acc_r + SUM_W'(rd_r);
    end
    if (cmd.finish) begin
      out_data_r.battery_percent <= avg;
      out_data_r.warning_event   <= evt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      fill_r      <= '0;
      walk_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      sev_r       <= bps_pkg::SEV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.walk_rd;
      if (cmd.write_entry) begin
        slot_r     <= (slot_r == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : slot_r + 1'b1;
        fill_r     <= ring_full ? fill_r : fill_r + 1'b1;
        walk_idx_r <= '0;
      end else if (cmd.walk_rd) begin
        walk_idx_r <= walk_idx_r + 1'b1;
      end
      if (cmd.finish) begin
        sev_r       <= sev_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done  = div_done;
  assign sts.walk_last = (FILL_W'(walk_idx_r) + 1'b1 == fill_r);
  assign sts.out_free  = ~out_valid_r | ~out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/battery_percent_smoother.sv
// one item at a time: in_stall is high from acceptance until the result,
// after the shared serial divider (8 + 8 bit steps) and the one-entry-per-cycle
// ring walk over the k samples averaged (1 to SAMPLE_COUNT), enters the output register
// a finished item waits in the output register while the next item is taken
// reset: synchronous active-low rst_n empties the ring, clears severity and
// loads the register defaults
module battery_percent_smoother #(
  parameter int SAMPLE_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bps_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data
);

  bps_pkg::cmd_t cmd;
  bps_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bps_datapath #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: design/bps_checker.sv
module bps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input bps_pkg::out_item_t             out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was taken");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.warning_event == bps_pkg::EVT_NONE ||
                  out_data.warning_event == bps_pkg::EVT_LOW ||
                  out_data.warning_event == bps_pkg::EVT_RADIO)
    else $error("unknown warning event code");

endmodule

bind battery_percent_smoother bps_checker u_bps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/battery_percent_checker.sv
module battery_percent_checker
  import bps_pkg::*;
#(
  parameter int SAMPLE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   readings_checked,
  output int                   low_warnings,
  output int                   radio_warnings
);

  localparam longint MV_SCALE_NUM = 156500000;
  localparam longint MV_SCALE_DEN = 99508500;

  logic [12:0]       critical_mv;
  logic [12:0]       span_mv;
  logic [9:0]        tenth_mv;
  logic [6:0]        warn_pct;
  logic [6:0]        radio_pct;
  logic signed [9:0] offset_mv;

  logic [7:0] ring [SAMPLE_COUNT];
  logic       ring_used [SAMPLE_COUNT];
  int         slot;
  logic [1:0] sev;

  out_item_t expected_readings[$];

  function automatic out_item_t grade_reading(input in_item_t item);
    longint    mv;
    longint    above;
    longint    scaled;
    longint    q;
    int        pct;
    int        entry;
    int        step;
    int        up;
    int        down;
    int        prev;
    int        sum;
    int        k;
    int        idx;
    int        avg;
    out_item_t res;

    // count to millivolts, then percent above the critical level
    mv = longint'(item.adc_count) * MV_SCALE_NUM / MV_SCALE_DEN + longint'(offset_mv);
    above = (mv > longint'(critical_mv)) ? mv - longint'(critical_mv) : 0;
    if (above > longint'(span_mv)) above = longint'(span_mv);
    if (tenth_mv == 0) begin
      pct = 255;
    end else begin
      scaled = above * 10;
      q = scaled / longint'(tenth_mv);
      if (scaled % longint'(tenth_mv) > longint'(tenth_mv >> 1)) q++;
      pct = (q > 255) ? 255 : int'(q);
    end

    // slew limit once the slot already holds a sample
    prev = (slot == 0) ? SAMPLE_COUNT - 1 : slot - 1;
    if (ring_used[slot]) begin
      up = item.charging ? SLEW_BIG : SLEW_SMALL;
      down = item.charging ? SLEW_SMALL : SLEW_BIG;
      step = pct - int'(ring[prev]);
      if (step > up) step = up;
      else if (step < -down) step = -down;
      entry = int'(ring[prev]) + step;
      if (entry < 0) entry = 0;
      if (entry > 255) entry = 255;
    end else begin
      entry = pct;
    end
    ring[slot] = 8'(entry);
    ring_used[slot] = 1'b1;

    sum = 0;
    k = 0;
    idx = slot;
    do begin
      sum += int'(ring[idx]);
      k++;
      idx = (idx == 0) ? SAMPLE_COUNT - 1 : idx - 1;
    end while (idx != slot && ring_used[idx]);

    if (k == 1) begin
      avg = sum;
    end else if (k < SAMPLE_COUNT) begin
      avg = sum / k;
      if (sum % k > (k >> 1)) avg++;
    end else begin
      avg = sum / SAMPLE_COUNT;
      if (sum % SAMPLE_COUNT >= (SAMPLE_COUNT >> 1)) avg++;
    end
    if (avg > 255) avg = 255;
    slot = (slot + 1) % SAMPLE_COUNT;

    res.warning_event = EVT_NONE;
    if (item.charging) begin
      sev = SEV_NONE;
    end else if (avg < int'(warn_pct)) begin
      if (avg < int'(radio_pct) && sev == SEV_LOW) begin
        sev = SEV_RADIO;
        res.warning_event = EVT_RADIO;
      end else if (avg >= int'(radio_pct) && sev == SEV_NONE) begin
        sev = SEV_LOW;
        res.warning_event = EVT_LOW;
      end
    end
    res.battery_percent = 8'(avg);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      critical_mv = CRITICAL_RST;
      span_mv = RANGE_RST;
      tenth_mv = TENTH_RST;
      warn_pct = WARN_RST;
      radio_pct = RADIO_OFF_RST;
      offset_mv = OFFSET_RST;
      for (int i = 0; i < SAMPLE_COUNT; i++) ring_used[i] = 1'b0;
      slot = 0;
      sev = SEV_NONE;
      expected_readings.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRITICAL:  critical_mv = cfg_data[12:0];
          REG_RANGE:     span_mv = cfg_data[12:0];
          REG_TENTH:     tenth_mv = cfg_data[9:0];
          REG_WARN:      warn_pct = cfg_data[6:0];
          REG_RADIO_OFF: radio_pct = cfg_data[6:0];
          REG_OFFSET:    offset_mv = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        readings_checked++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected reading percent %0d event %0d", $time,
                     out_data.battery_percent, out_data.warning_event);
        end else begin
          want = expected_readings.pop_front();
          if (want.warning_event == EVT_LOW) low_warnings++;
          if (want.warning_event == EVT_RADIO) radio_warnings++;
          if (out_data.battery_percent !== want.battery_percent ||
              out_data.warning_event !== want.warning_event) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: reading mismatch: percent %0d event %0d, expected %0d event %0d",
                       $time, out_data.battery_percent, out_data.warning_event,
                       want.battery_percent, want.warning_event);
          end
        end
      end
      if (in_valid && !in_stall) expected_readings.push_back(grade_reading(in_data));
      outstanding = expected_readings.size();
    end
  end

endmodule

// File: bench/battery_percent_smoother_tb.sv
module battery_percent_smoother_tb;

  import bps_pkg::*;

  localparam int RX_HOLD_CYCLES = 600;
  localparam int DRILL_LEN = 19;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CRITICAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int readings_checked;
  int low_warnings;
  int radio_warnings;

  bit rx_hold_req = 1'b0;
  bit charging_now = 1'b0;
  int win_lo;
  int win_hi;
  int trace;
  int settings_used = 0;

  battery_percent_smoother DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  battery_percent_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .readings_checked (readings_checked),
    .low_warnings     (low_warnings),
    .radio_warnings   (radio_warnings)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len(input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, long_max);
  endfunction

  task automatic send_reading(input in_item_t item, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    mask = CFG_DATA_W'((1 << width) - 1);
    data = CFG_DATA_W'(value) & mask;
    // sometimes junk above the register width
    if ($urandom_range(0, 3) == 0) data = data | (CFG_DATA_W'($urandom) & ~mask);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_levels(input int crit, input int span, input int tenth,
                            input int warn, input int radio, input int off);
    wait_drained();
    write_reg(REG_CRITICAL, crit, 13);
    write_reg(REG_RANGE, span, 13);
    write_reg(REG_TENTH, tenth, 10);
    write_reg(REG_WARN, warn, 7);
    write_reg(REG_RADIO_OFF, radio, 7);
    write_reg(REG_OFFSET, off, 10);
    settings_used++;
    // adc counts that land between critical and full
    win_lo = ((crit - off) * 63584) / 100000 - 20;
    win_hi = ((crit - off + span) * 63584) / 100000 + 20;
    if (win_lo < 0) win_lo = 0;
    if (win_lo > 4095) win_lo = 4095;
    if (win_hi < 0) win_hi = 0;
    if (win_hi > 4095) win_hi = 4095;
    if (win_lo > win_hi) win_lo = win_hi;
    trace = $urandom_range(win_lo, win_hi);
  endtask

  task automatic run_readings(input int n, input int hold_at);
    in_item_t item;
    int       r;
    bit       burst;
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 29) == 0) charging_now = !charging_now;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // slow drain or charge inside the working window
        if (charging_now) trace += int'($urandom_range(0, 12)) - 3;
        else trace += int'($urandom_range(0, 12)) - 9;
        if (trace < win_lo) trace = win_lo;
        if (trace > win_hi) trace = win_hi;
        item.adc_count = ADC_W'(trace);
        item.charging = charging_now;
      end else if (r < 90) begin
        item.adc_count = ADC_W'($urandom_range(0, 4095));
        item.charging = 1'($urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 3))
          0: item.adc_count = '0;
          1: item.adc_count = '1;
          2: item.adc_count = ADC_W'(win_lo);
          default: item.adc_count = ADC_W'(win_hi);
        endcase
        item.charging = charging_now;
      end
      send_reading(item, burst ? 0 : gap_len(40));
      if (i == hold_at) rx_hold_req = 1'b1;
    end
  endtask

  initial begin : receiver
    int stall_left;
    int cyc;
    bit quiet;
    stall_left = 0;
    cyc = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        stall_left = 0;
        rx_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = 1 + gap_len(60);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned drill_count [DRILL_LEN] = '{0, 4095, 2283, 2283, 2283, 2283, 0, 0, 0, 0,
                                             0, 0, 2225, 2226, 4095, 4095, 4095, 4095, 2226};
    bit          drill_chg [DRILL_LEN] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                                           0, 0, 1, 1, 1, 1, 1, 0, 0};
    in_item_t    item;
    int          crit;
    int          span;
    int          tenth;
    int          warn;
    int          radio;
    int          off;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset levels: fill, low warning, radio off, charge recovery
    for (int i = 0; i < DRILL_LEN; i++) begin
      item.adc_count = ADC_W'(drill_count[i]);
      item.charging = drill_chg[i];
      send_reading(item, gap_len(40));
    end

    set_levels(CRITICAL_RST, RANGE_RST, TENTH_RST, WARN_RST, RADIO_OFF_RST, 0);
    run_readings(300, 120);
    set_levels(0, 8191, 1023, 100, 0, -512);
    run_readings(60, -1);
    set_levels(8191, 1, 1, 0, 100, 511);
    write_reg(REG_SPARE, $urandom, 13);
    run_readings(60, -1);
    // zero divisor and zero span
    set_levels(3000, 0, 0, 50, 20, 100);
    run_readings(60, -1);
    set_levels(3000, 100, 1, 127, 127, -300);
    run_readings(80, -1);

    repeat (5) begin
      crit = $urandom_range(2000, 5000);
      span = $urandom_range(50, 2000);
      if ($urandom_range(0, 3) != 0) begin
        tenth = span / 10;
        if (tenth < 1) tenth = 1;
      end else begin
        tenth = $urandom_range(1, 1023);
      end
      warn = $urandom_range(5, 100);
      radio = $urandom_range(0, warn);
      off = int'($urandom_range(0, 1023)) - 512;
      set_levels(crit, span, tenth, warn, radio, off);
      run_readings(200, -1);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("summary: %0d readings checked across %0d register settings",
             readings_checked, settings_used);
    $display("summary: %0d low-battery and %0d radio-off warnings predicted",
             low_warnings, radio_warnings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
